// File: sv/lgst_pkg.sv
package lgst_pkg;

   localparam int PORTS      = 16;
   localparam int GROUPS     = 4;
   localparam int DELAY_BITS = 16;

   // Layout of the packed configuration registers.
   localparam int FIELD_BITS = 16;
   localparam int MIN_BITS   = 5;
   localparam int COUNT_BITS = $clog2(PORTS + 1);

   localparam int CSR_DATA_BITS  = 64;
   localparam int CSR_INDEX_BITS = 2;
   localparam int MIN_REG_BITS   = 20;
   localparam logic [MIN_REG_BITS-1:0] MIN_REG_RESET = 20'd33825;

   localparam int STATES_BITS = 8;
   localparam int FORCE_BITS  = 16;

   localparam logic CMD_REPORT = 1'b0;
   localparam logic CMD_TICK   = 1'b1;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_UPLINK   = 2'd0,
      CSR_DOWNLINK = 2'd1,
      CSR_MIN_UP   = 2'd2,
      CSR_DELAYS   = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      GS_DOWN    = 2'd0,
      GS_PENDING = 2'd1,
      GS_UP      = 2'd2
   } gstate_type;

   typedef struct packed {
      logic       cmd;
      logic [3:0] port_index;
      logic       port_up;
   } req_type;

   typedef struct packed {
      logic [STATES_BITS-1:0] group_states;
      logic [FORCE_BITS-1:0]  force_down_mask;
   } rsp_type;

   typedef struct packed {
      logic [CSR_DATA_BITS-1:0] uplink;
      logic [CSR_DATA_BITS-1:0] downlink;
      logic [MIN_REG_BITS-1:0]  min_up;
      logic [CSR_DATA_BITS-1:0] delays;
   } cfg_type;

   function automatic logic [COUNT_BITS-1:0] popcount(input logic [PORTS-1:0] v);
      logic [COUNT_BITS-1:0] n;
      n = '0;
      for (int i = 0; i < PORTS; i++) begin
         n = n + COUNT_BITS'(v[i]);
      end
      return n;
   endfunction

endpackage

// File: sv/lgst_csr.sv
module lgst_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_en,
   input  logic [lgst_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [lgst_pkg::CSR_DATA_BITS-1:0]   csr_wdata,
   output lgst_pkg::cfg_type                    cfg
);

   lgst_pkg::cfg_type cfg_ff;
   lgst_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         unique case (lgst_pkg::csr_index_type'(csr_index))
            lgst_pkg::CSR_UPLINK:   cfg_in.uplink   = csr_wdata;
            lgst_pkg::CSR_DOWNLINK: cfg_in.downlink = csr_wdata;
            lgst_pkg::CSR_MIN_UP:   cfg_in.min_up   = csr_wdata[lgst_pkg::MIN_REG_BITS-1:0];
            lgst_pkg::CSR_DELAYS:   cfg_in.delays   = csr_wdata;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.uplink   <= '0;
         cfg_ff.downlink <= '0;
         cfg_ff.min_up   <= lgst_pkg::MIN_REG_RESET;
         cfg_ff.delays   <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: sv/lgst_core.sv
module lgst_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  lgst_pkg::req_type req,
   input  lgst_pkg::cfg_type cfg,
   output lgst_pkg::rsp_type rsp
);

   logic [lgst_pkg::PORTS-1:0]      ports_ff;
   logic [lgst_pkg::PORTS-1:0]      ports_in;
   lgst_pkg::gstate_type            state_ff [lgst_pkg::GROUPS];
   lgst_pkg::gstate_type            state_in [lgst_pkg::GROUPS];
   logic [lgst_pkg::DELAY_BITS-1:0] cnt_ff   [lgst_pkg::GROUPS];
   logic [lgst_pkg::DELAY_BITS-1:0] cnt_in   [lgst_pkg::GROUPS];

   // Port status update; an index beyond the port count matches no bit.
   always_comb begin
      ports_in = ports_ff;
      if (req.cmd == lgst_pkg::CMD_REPORT) begin
         for (int p = 0; p < lgst_pkg::PORTS; p++) begin
            if (req.port_index == 4'(p)) begin
               ports_in[p] = req.port_up;
            end
         end
      end
   end

   always_comb begin
      logic [lgst_pkg::PORTS-1:0]      ups;
      logic [lgst_pkg::MIN_BITS-1:0]   need;
      logic [lgst_pkg::DELAY_BITS-1:0] dly;
      logic                            ok;
      lgst_pkg::gstate_type            st;
      logic [lgst_pkg::DELAY_BITS-1:0] cnt;
      rsp.group_states    = '0;
      rsp.force_down_mask = '0;
      for (int g = 0; g < lgst_pkg::GROUPS; g++) begin
         ups  = cfg.uplink[lgst_pkg::FIELD_BITS*g +: lgst_pkg::PORTS] & ports_in;
         need = cfg.min_up[lgst_pkg::MIN_BITS*g +: lgst_pkg::MIN_BITS];
         dly  = cfg.delays[lgst_pkg::FIELD_BITS*g +: lgst_pkg::DELAY_BITS];
         ok   = {{(lgst_pkg::MIN_BITS+1-lgst_pkg::COUNT_BITS){1'b0}},
                 lgst_pkg::popcount(ups)} >= {1'b0, need};
         st   = state_ff[g];
         cnt  = cnt_ff[g];
         // A tick runs the delay down first; expiry rechecks the uplink count.
         if (req.cmd == lgst_pkg::CMD_TICK && st == lgst_pkg::GS_PENDING) begin
            if (cnt != '0) begin
               cnt = cnt - 1'b1;
            end
            if (cnt == '0) begin
               st = ok ? lgst_pkg::GS_UP : lgst_pkg::GS_DOWN;
            end
         end
         if (ok && st == lgst_pkg::GS_DOWN) begin
            if (dly != '0) begin
               st  = lgst_pkg::GS_PENDING;
               cnt = dly;
            end else begin
               st = lgst_pkg::GS_UP;
            end
         end else if (!ok && st != lgst_pkg::GS_DOWN) begin
            st  = lgst_pkg::GS_DOWN;
            cnt = '0;
         end
         state_in[g] = st;
         cnt_in[g]   = cnt;
         rsp.group_states[2*g +: 2] = st;
         if (st != lgst_pkg::GS_UP) begin
            rsp.force_down_mask[lgst_pkg::PORTS-1:0] =
               rsp.force_down_mask[lgst_pkg::PORTS-1:0] |
               cfg.downlink[lgst_pkg::FIELD_BITS*g +: lgst_pkg::PORTS];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ports_ff <= '0;
         for (int g = 0; g < lgst_pkg::GROUPS; g++) begin
            state_ff[g] <= lgst_pkg::GS_DOWN;
            cnt_ff[g]   <= '0;
         end
      end else if (advance) begin
         ports_ff <= ports_in;
         for (int g = 0; g < lgst_pkg::GROUPS; g++) begin
            state_ff[g] <= state_in[g];
            cnt_ff[g]   <= cnt_in[g];
         end
      end
   end

endmodule

// File: sv/link_group_state_tracker.sv
// Link group state tracker.
// Requests arrive on the req_ channel (valid/ready): each is either a port
// status report or one link-up delay tick. Every request yields exactly one
// response on the rsp_ channel carrying all group states and the mask of
// downlink ports that must be held down.
// A request is captured in an input register; once the response register is
// free the group evaluation runs and its result, together with the updated
// port and group state, is written into the response register. One request
// is taken per cycle sustained while the receiver keeps rsp_ready high; a
// single evaluation pass lies between the two registers.
// While rsp_valid is held by a stalled receiver, one further request can
// wait in the input register; req_ready drops only when both are full.
// Configuration registers are written through the csr_ port and apply from
// the next request evaluated. Synchronous reset clears all ports and groups
// to down, the delay counters to zero and the minimum to one uplink per group.
module link_group_state_tracker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  lgst_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output lgst_pkg::rsp_type                   rsp_data,
   input  logic                                csr_write_en,
   input  logic [lgst_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [lgst_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);

   logic              in_valid_ff;
   logic              in_valid_in;
   lgst_pkg::req_type in_data_ff;
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   lgst_pkg::rsp_type rsp_data_ff;
   lgst_pkg::rsp_type rsp_next;
   lgst_pkg::cfg_type cfg;
   logic              out_free;
   logic              advance;

   assign out_free     = !rsp_valid_ff || rsp_ready;
   assign advance      = in_valid_ff && out_free;
   assign req_ready    = !in_valid_ff || advance;
   assign in_valid_in  = (req_valid && req_ready) || (in_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_ready);

   lgst_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cfg          (cfg)
   );

   lgst_core u_core (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .req     (in_data_ff),
      .cfg     (cfg),
      .rsp     (rsp_next)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         rsp_data_ff <= rsp_next;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// File: sv/lgst_checker.sv
module lgst_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input lgst_pkg::rsp_type rsp_data
);

   logic all_up;
   logic bad_code;

   always_comb begin
      all_up   = 1'b1;
      bad_code = 1'b0;
      for (int g = 0; g < lgst_pkg::GROUPS; g++) begin
         if (rsp_data.group_states[2*g +: 2] != lgst_pkg::GS_UP) begin
            all_up = 1'b0;
         end
         if (rsp_data.group_states[2*g +: 2] == 2'b11) begin
            bad_code = 1'b1;
         end
      end
   end

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid directly after reset");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request refused while the response register is empty");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   a_state_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !bad_code)
      else $error("group reported with an undefined state code");

   a_all_up_no_force: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && all_up |-> rsp_data.force_down_mask == '0)
      else $error("port forced down although every group is up");

endmodule

bind link_group_state_tracker lgst_checker u_lgst_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

// File: sim/tb_link_group_state_tracker.sv
`timescale 1ns / 1ps

module tb_link_group_state_tracker;
   import lgst_pkg::*;

   class link_group_checker;
      logic [CSR_DATA_BITS-1:0] uplink;
      logic [CSR_DATA_BITS-1:0] downlink;
      logic [MIN_REG_BITS-1:0]  min_up;
      logic [CSR_DATA_BITS-1:0] delays;
      logic [PORTS-1:0]         ports_up;
      gstate_type               gst[GROUPS];
      logic [DELAY_BITS-1:0]    delay_left[GROUPS];
      rsp_type                  expected_states_q[$];
      int                       errors;
      int                       checked;

      function new();
         clear();
      endfunction

      function void clear();
         uplink   = '0;
         downlink = '0;
         min_up   = MIN_REG_RESET;
         delays   = '0;
         ports_up = '0;
         for (int g = 0; g < GROUPS; g++) begin
            gst[g]        = GS_DOWN;
            delay_left[g] = '0;
         end
         expected_states_q.delete();
      endfunction

      function void set_config(cfg_type c);
         uplink   = c.uplink;
         downlink = c.downlink;
         min_up   = c.min_up;
         delays   = c.delays;
      endfunction

      function bit uplinks_met(int g);
         logic [PORTS-1:0] ups;
         int               need;
         ups  = uplink[FIELD_BITS*g +: PORTS] & ports_up;
         need = int'(min_up[MIN_BITS*g +: MIN_BITS]);
         return $countones(ups) >= need;
      endfunction

      function void report(string msg);
         errors++;
         if (errors <= 10) $display("%0t ns: %s", $time, msg);
      endfunction

      function void note_request(req_type r);
         logic [STATES_BITS-1:0] states;
         logic [FORCE_BITS-1:0]  force_mask;
         logic [DELAY_BITS-1:0]  d;
         rsp_type                e;
         bit                     ok;
         states     = '0;
         force_mask = '0;
         if (r.cmd == CMD_REPORT) begin
            if (int'(r.port_index) < PORTS) ports_up[r.port_index] = r.port_up;
         end else begin
            // The countdown runs before the groups are evaluated.
            for (int g = 0; g < GROUPS; g++) begin
               if (gst[g] == GS_PENDING) begin
                  if (delay_left[g] != 0) delay_left[g] = delay_left[g] - 1'b1;
                  if (delay_left[g] == 0) gst[g] = uplinks_met(g) ? GS_UP : GS_DOWN;
               end
            end
         end
         for (int g = 0; g < GROUPS; g++) begin
            ok = uplinks_met(g);
            if (ok && gst[g] == GS_DOWN) begin
               d = delays[FIELD_BITS*g +: DELAY_BITS];
               if (d != 0) begin
                  gst[g]        = GS_PENDING;
                  delay_left[g] = d;
               end else begin
                  gst[g] = GS_UP;
               end
            end else if (!ok && gst[g] != GS_DOWN) begin
               gst[g]        = GS_DOWN;
               delay_left[g] = '0;
            end
            states[2*g +: 2] = gst[g];
            if (gst[g] != GS_UP) force_mask |= downlink[FIELD_BITS*g +: PORTS];
         end
         e.group_states    = states;
         e.force_down_mask = force_mask;
         expected_states_q.push_back(e);
      endfunction

      function void check_response(rsp_type got);
         rsp_type e;
         if (expected_states_q.size() == 0) begin
            report($sformatf("unexpected response: states %02h force %04h",
                             got.group_states, got.force_down_mask));
            return;
         end
         e = expected_states_q.pop_front();
         checked++;
         if (got.group_states !== e.group_states ||
             got.force_down_mask !== e.force_down_mask)
            report($sformatf("mismatch: expected states %02h force %04h, got states %02h force %04h",
                             e.group_states, e.force_down_mask,
                             got.group_states, got.force_down_mask));
      endfunction
   endclass

   logic                      clock        = 1'b0;
   logic                      reset        = 1'b1;
   logic                      req_valid    = 1'b0;
   logic                      req_ready;
   req_type                   req_data     = '0;
   logic                      rsp_valid;
   logic                      rsp_ready    = 1'b0;
   rsp_type                   rsp_data;
   logic                      csr_write_en = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index    = '0;
   logic [CSR_DATA_BITS-1:0]  csr_wdata    = '0;

   link_group_checker checker_h = new();

   bit rx_random    = 1'b1;
   bit tx_random    = 1'b1;
   bit hold_request = 1'b0;
   int hold_left    = 0;
   int stall_left   = 0;
   int requests     = 0;
   int settings     = 0;

   link_group_state_tracker i_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always #6 clock = ~clock;

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            checker_h.note_request(req_data);
            requests++;
         end
         if (rsp_valid && rsp_ready) checker_h.check_response(rsp_data);
      end
   end

   // The receiver decides its ready once per falling edge; a long hold-off is
   // counted here so that the sender keeps offering requests meanwhile.
   always @(negedge clock) begin
      if (hold_request) begin
         hold_request = 1'b0;
         hold_left    = 80;
      end
      if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left--;
      end else if (stall_left > 0) begin
         rsp_ready <= 1'b0;
         stall_left--;
      end else begin
         rsp_ready <= 1'b1;
         if (rx_random && $urandom_range(0, 99) < 30) stall_left = pick_gap();
      end
   end

   task automatic send_request(req_type r);
      int gap;
      gap = tx_random ? pick_gap() : 0;
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic send(logic cmd, int port, logic up);
      req_type r;
      r.cmd        = cmd;
      r.port_index = 4'(port);
      r.port_up    = up;
      send_request(r);
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (checker_h.expected_states_q.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic load_config(cfg_type c);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= CSR_UPLINK;
      csr_wdata    <= c.uplink;
      @(negedge clock);
      csr_index    <= CSR_DOWNLINK;
      csr_wdata    <= c.downlink;
      @(negedge clock);
      // Bits above the minimum field carry noise that the block must drop.
      csr_index    <= CSR_MIN_UP;
      csr_wdata    <= {32'($urandom()), 12'($urandom()), c.min_up};
      @(negedge clock);
      csr_index    <= CSR_DELAYS;
      csr_wdata    <= c.delays;
      @(negedge clock);
      csr_write_en <= 1'b0;
      checker_h.set_config(c);
      settings++;
   endtask

   function automatic cfg_type random_config();
      cfg_type c;
      int      r;
      for (int g = 0; g < GROUPS; g++) begin
         r = $urandom_range(0, 9);
         c.uplink[16*g +: 16] = (r == 0) ? 16'h0000 : (r == 1) ? 16'hFFFF : 16'($urandom());
         r = $urandom_range(0, 9);
         c.downlink[16*g +: 16] = (r == 0) ? 16'h0000 : (r == 1) ? 16'hFFFF : 16'($urandom());
         r = $urandom_range(0, 9);
         c.min_up[5*g +: 5] = (r < 7) ? 5'($urandom_range(0, 4)) :
                              (r < 9) ? 5'($urandom_range(5, 16)) : 5'($urandom_range(17, 31));
         r = $urandom_range(0, 9);
         c.delays[16*g +: 16] = (r < 3) ? 16'd0 : (r < 9) ? 16'($urandom_range(1, 6)) :
                                16'($urandom());
      end
      return c;
   endfunction

   task automatic random_requests(int count, int hold_at);
      req_type r;
      for (int i = 0; i < count; i++) begin
         if (i == hold_at) begin
            hold_request = 1'b1;
            tx_random    = 1'b0;
         end
         if (i == hold_at + 12) tx_random = 1'b1;
         r.cmd        = ($urandom_range(0, 99) < 30) ? CMD_TICK : CMD_REPORT;
         r.port_index = 4'($urandom_range(0, PORTS - 1));
         r.port_up    = ($urandom_range(0, 99) < 60);
         send_request(r);
      end
   endtask

   initial begin
      #4_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   initial begin
      cfg_type c;
      int      waited;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // At reset no port is an uplink, so a report leaves every group down.
      send(CMD_REPORT, 0, 1'b1);
      send(CMD_TICK, 0, 1'b0);
      wait_drained();

      c.uplink   = {16'h8000, 16'hFFFF, 16'h00F0, 16'h0003};
      c.downlink = {16'hFFFF, 16'h0F0F, 16'h000F, 16'hFF00};
      c.min_up   = {5'd1, 5'd17, 5'd0, 5'd2};
      c.delays   = {16'hFFFF, 16'd5, 16'd0, 16'd3};
      load_config(c);
      send(CMD_REPORT, 0, 1'b1);
      send(CMD_REPORT, 1, 1'b1);
      send(CMD_REPORT, 1, 1'b1);
      send(CMD_TICK, 7, 1'b1);
      send(CMD_TICK, 0, 1'b0);
      send(CMD_TICK, 15, 1'b0);
      send(CMD_REPORT, 15, 1'b1);
      send(CMD_TICK, 0, 1'b0);
      send(CMD_REPORT, 15, 1'b0);
      send(CMD_REPORT, 1, 1'b0);
      send(CMD_REPORT, 1, 1'b1);
      send(CMD_TICK, 0, 1'b0);
      wait_drained();

      // A delay written while the group is pending leaves the running count alone.
      c.delays = {16'hFFFF, 16'd5, 16'd0, 16'd1};
      load_config(c);
      send(CMD_TICK, 0, 1'b0);
      send(CMD_TICK, 0, 1'b0);
      send(CMD_REPORT, 0, 1'b0);
      wait_drained();

      c.uplink   = {4{16'hFFFF}};
      c.min_up   = {5'd31, 5'd16, 5'd0, 5'd16};
      c.delays   = {16'd0, 16'd2, 16'd0, 16'd0};
      load_config(c);
      for (int p = 0; p < PORTS; p++) send(CMD_REPORT, p, 1'b1);
      send(CMD_TICK, 0, 1'b0);
      send(CMD_TICK, 0, 1'b0);
      wait_drained();

      for (int k = 0; k < 8; k++) begin
         if (k == 0) begin
            c = '0;
         end else if (k == 1) begin
            c.uplink   = '1;
            c.downlink = '1;
            c.min_up   = '1;
            c.delays   = '1;
         end else begin
            c = random_config();
         end
         load_config(c);
         tx_random = (k % 3 != 2);
         rx_random = (k % 3 != 2);
         random_requests(48, (k == 3 || k == 6) ? 10 : -100);
         if (k == 4) begin
            // The sender waits here until every response has come back.
            wait_drained();
            random_requests(8, -100);
         end
         wait_drained();
      end
      tx_random = 1'b1;
      rx_random = 1'b1;

      waited = 0;
      while (checker_h.expected_states_q.size() != 0 && waited < 5000) begin
         @(posedge clock);
         waited++;
      end
      repeat (4) @(posedge clock);
      if (checker_h.expected_states_q.size() != 0)
         checker_h.report($sformatf("%0d responses never arrived",
                                    checker_h.expected_states_q.size()));
      $display("Run covered %0d requests under %0d register settings; %0d responses checked.",
               requests, settings, checker_h.checked);
      $display("Errors found: %0d.", checker_h.errors);
      if (checker_h.errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// File: link_group_state_tracker.f
sv/lgst_pkg.sv
sv/lgst_csr.sv
sv/lgst_core.sv
sv/link_group_state_tracker.sv
sv/lgst_checker.sv
sim/tb_link_group_state_tracker.sv
